/* design/mtrb_pkg.sv */
// types and codes shared by the trace ring buffer bank
// used by the top level
`timescale 1ns / 1ps

package mtrb_pkg;

    // command codes of one input beat
    typedef enum logic [1:0] {
        CMD_TGT_PUT   = 2'd0,
        CMD_TGT_GET   = 2'd1,
        CMD_HOST_TAKE = 2'd2,
        CMD_HOST_PUT  = 2'd3
    } t_cmd;

    // status codes of one result beat
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAN = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // item after the memory access has been issued
    typedef struct packed {
        t_status    status;
        logic       rd_up;
        logic       rd_dn;
        logic [7:0] up_fill;
        logic [7:0] down_fill;
        logic       burst_last;
    } t_stage;

    // finished result held in the output register
    typedef struct packed {
        t_status    status;
        logic [7:0] data_out;
        logic [7:0] up_fill;
        logic [7:0] down_fill;
        logic       burst_last_out;
    } t_result;

endpackage

/* design/mtrb_ifs.sv */
// valid/ready channel interfaces for command and result beats
// no dependencies
`timescale 1ns / 1ps

interface mtrb_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [2:0] channel;
    logic [7:0] data_in;
    logic       burst_last;

    modport source (output valid, output cmd, output channel, output data_in,
                    output burst_last, input ready);
    modport sink (input valid, input cmd, input channel, input data_in,
                  input burst_last, output ready);
endinterface

interface mtrb_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] data_out;
    logic [7:0] up_fill;
    logic [7:0] down_fill;
    logic       burst_last_out;

    modport source (output valid, output status, output data_out, output up_fill,
                    output down_fill, output burst_last_out, input ready);
    modport sink (input valid, input status, input data_out, input up_fill,
                  input down_fill, input burst_last_out, output ready);
endinterface

/* design/multichannel_trace_ring_buffers_top.sv */
// bank of up and down byte ring buffers with free-running offsets
// depends on mtrb_pkg, mtrb_ifs and mtrb_ring_mem
`timescale 1ns / 1ps

// a result passes through stage one and the output register before it is offered
// throughput: one beat per cycle while results are taken, set by one store access per beat on each memory
// offsets sit in flip-flops and are updated at accept; store reads are registered
// a stalled result holds one more accepted beat before the input is held off
// reset (synchronous, active low) zeroes all offsets and empties the pipeline
// the byte stores are not cleared: an entry is only read after it was written
module multichannel_trace_ring_buffers_top #(
    parameter int UP_COUNT   = 2,
    parameter int DOWN_COUNT = 2,
    parameter int RING_BYTES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mtrb_cmd_if.sink     i_cmd_ch,
    mtrb_res_if.source   o_res_ch
);

    localparam int IW    = $clog2(RING_BYTES);
    localparam int OW    = IW + 1;
    localparam int UP_CW = (UP_COUNT > 1) ? $clog2(UP_COUNT) : 1;
    localparam int DN_CW = (DOWN_COUNT > 1) ? $clog2(DOWN_COUNT) : 1;

    // fill level clamped to one byte
    function automatic logic [7:0] sat8(input logic [OW-1:0] v);
        logic [31:0] v_w;
        v_w = 32'(v);
        return (v_w > 32'd255) ? 8'hFF : v_w[7:0];
    endfunction

    logic [OW-1:0] r_up_wr [UP_COUNT];
    logic [OW-1:0] r_up_rd [UP_COUNT];
    logic [OW-1:0] r_dn_wr [DOWN_COUNT];
    logic [OW-1:0] r_dn_rd [DOWN_COUNT];

    logic               r_s1_valid;
    mtrb_pkg::t_stage   r_s1;
    logic               r_s2_valid;
    mtrb_pkg::t_result  r_s2;

    logic               acc;
    logic               s1_adv;
    logic               up_ok;
    logic               dn_ok;
    logic [UP_CW-1:0]   up_sel;
    logic [DN_CW-1:0]   dn_sel;
    logic [OW-1:0]      up_wr_cur;
    logic [OW-1:0]      up_rd_cur;
    logic [OW-1:0]      dn_wr_cur;
    logic [OW-1:0]      dn_rd_cur;
    logic [OW-1:0]      up_lvl;
    logic [OW-1:0]      dn_lvl;
    logic [OW-1:0]      n_up_wr;
    logic [OW-1:0]      n_up_rd;
    logic [OW-1:0]      n_dn_wr;
    logic [OW-1:0]      n_dn_rd;
    logic               up_put;
    logic               up_take;
    logic               dn_put;
    logic               dn_get;
    mtrb_pkg::t_status  status;
    mtrb_pkg::t_stage   n_s1;
    logic [7:0]         up_rdata;
    logic [7:0]         dn_rdata;
    logic [7:0]         s1_data;

    // handshake and pipeline advance
    assign s1_adv         = !r_s2_valid || o_res_ch.ready;
    assign i_cmd_ch.ready = !r_s1_valid || s1_adv;
    assign acc            = i_cmd_ch.valid && i_cmd_ch.ready;

    // channel decode and current offsets
    assign up_ok     = 32'(i_cmd_ch.channel) < UP_COUNT;
    assign dn_ok     = 32'(i_cmd_ch.channel) < DOWN_COUNT;
    assign up_sel    = up_ok ? i_cmd_ch.channel[UP_CW-1:0] : '0;
    assign dn_sel    = dn_ok ? i_cmd_ch.channel[DN_CW-1:0] : '0;
    assign up_wr_cur = r_up_wr[up_sel];
    assign up_rd_cur = r_up_rd[up_sel];
    assign dn_wr_cur = r_dn_wr[dn_sel];
    assign dn_rd_cur = r_dn_rd[dn_sel];
    assign up_lvl    = up_wr_cur - up_rd_cur;
    assign dn_lvl    = dn_wr_cur - dn_rd_cur;

    // command decode with full, empty and bad channel checks
    always_comb begin
        status  = mtrb_pkg::ST_BAD_CHAN;
        up_put  = 1'b0;
        up_take = 1'b0;
        dn_put  = 1'b0;
        dn_get  = 1'b0;
        case (i_cmd_ch.cmd)
            mtrb_pkg::CMD_TGT_PUT: begin
                if (up_ok) begin
                    if (up_lvl == OW'(RING_BYTES - 1)) begin
                        status = mtrb_pkg::ST_FULL;
                    end else begin
                        status = mtrb_pkg::ST_OK;
                        up_put = 1'b1;
                    end
                end
            end
            mtrb_pkg::CMD_TGT_GET: begin
                if (dn_ok) begin
                    if (dn_lvl == '0) begin
                        status = mtrb_pkg::ST_EMPTY;
                    end else begin
                        status = mtrb_pkg::ST_OK;
                        dn_get = 1'b1;
                    end
                end
            end
            mtrb_pkg::CMD_HOST_TAKE: begin
                if (up_ok) begin
                    if (up_lvl == '0) begin
                        status = mtrb_pkg::ST_EMPTY;
                    end else begin
                        status  = mtrb_pkg::ST_OK;
                        up_take = 1'b1;
                    end
                end
            end
            mtrb_pkg::CMD_HOST_PUT: begin
                if (dn_ok) begin
                    if (dn_lvl == OW'(RING_BYTES - 1)) begin
                        status = mtrb_pkg::ST_FULL;
                    end else begin
                        status = mtrb_pkg::ST_OK;
                        dn_put = 1'b1;
                    end
                end
            end
            default: begin
                status = mtrb_pkg::ST_BAD_CHAN;
            end
        endcase
    end

    // offsets after the step and the fill levels they give
    assign n_up_wr = up_wr_cur + OW'(up_put);
    assign n_up_rd = up_rd_cur + OW'(up_take);
    assign n_dn_wr = dn_wr_cur + OW'(dn_put);
    assign n_dn_rd = dn_rd_cur + OW'(dn_get);

    always_comb begin
        n_s1.status     = status;
        n_s1.rd_up      = up_take;
        n_s1.rd_dn      = dn_get;
        n_s1.up_fill    = up_ok ? sat8(n_up_wr - n_up_rd) : 8'd0;
        n_s1.down_fill  = dn_ok ? sat8(n_dn_wr - n_dn_rd) : 8'd0;
        n_s1.burst_last = i_cmd_ch.burst_last;
    end

    // offset registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < UP_COUNT; i++) begin
                r_up_wr[i] <= '0;
                r_up_rd[i] <= '0;
            end
            for (int i = 0; i < DOWN_COUNT; i++) begin
                r_dn_wr[i] <= '0;
                r_dn_rd[i] <= '0;
            end
        end else if (acc) begin
            r_up_wr[up_sel] <= n_up_wr;
            r_up_rd[up_sel] <= n_up_rd;
            r_dn_wr[dn_sel] <= n_dn_wr;
            r_dn_rd[dn_sel] <= n_dn_rd;
        end
    end

    // byte stores, one per direction
    mtrb_ring_mem #(
        .DEPTH (UP_COUNT * RING_BYTES),
        .AW    (UP_CW + IW)
    ) u_up_mem (
        .i_clk   (i_clk),
        .i_we    (acc && up_put),
        .i_waddr ({up_sel, up_wr_cur[IW-1:0]}),
        .i_wdata (i_cmd_ch.data_in),
        .i_re    (acc && up_take),
        .i_raddr ({up_sel, up_rd_cur[IW-1:0]}),
        .o_rdata (up_rdata)
    );

    mtrb_ring_mem #(
        .DEPTH (DOWN_COUNT * RING_BYTES),
        .AW    (DN_CW + IW)
    ) u_dn_mem (
        .i_clk   (i_clk),
        .i_we    (acc && dn_put),
        .i_waddr ({dn_sel, dn_wr_cur[IW-1:0]}),
        .i_wdata (i_cmd_ch.data_in),
        .i_re    (acc && dn_get),
        .i_raddr ({dn_sel, dn_rd_cur[IW-1:0]}),
        .o_rdata (dn_rdata)
    );

    // stage one: waits for the store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1 <= n_s1;
        end
    end

    // fetched byte, zero unless a get or take succeeded
    assign s1_data = r_s1.rd_up ? up_rdata : (r_s1.rd_dn ? dn_rdata : 8'd0);

    // stage two: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_s2.status         <= r_s1.status;
            r_s2.data_out       <= s1_data;
            r_s2.up_fill        <= r_s1.up_fill;
            r_s2.down_fill      <= r_s1.down_fill;
            r_s2.burst_last_out <= r_s1.burst_last;
        end
    end

    // result beat
    assign o_res_ch.valid          = r_s2_valid;
    assign o_res_ch.status         = r_s2.status;
    assign o_res_ch.data_out       = r_s2.data_out;
    assign o_res_ch.up_fill        = r_s2.up_fill;
    assign o_res_ch.down_fill      = r_s2.down_fill;
    assign o_res_ch.burst_last_out = r_s2.burst_last_out;

`ifndef SYNTHESIS
    // channel 0 never holds more than the ring less one byte
    a_up_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_up_wr[0] - r_up_rd[0]) <= OW'(RING_BYTES - 1))
        else $error("up channel 0 over filled");

    a_dn_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dn_wr[0] - r_dn_rd[0]) <= OW'(RING_BYTES - 1))
        else $error("down channel 0 over filled");

    // a failed step never returns a byte
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2.status != mtrb_pkg::ST_OK) |-> (r_s2.data_out == 8'd0))
        else $error("data on a failed step");

    // a rejected beat leaves the channel 0 offsets alone
    a_bad_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && status != mtrb_pkg::ST_OK) |=>
        ($stable(r_up_wr[0]) && $stable(r_up_rd[0]) &&
         $stable(r_dn_wr[0]) && $stable(r_dn_rd[0])))
        else $error("offsets moved on a rejected beat");

    // read data held while stage one waits
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> ($stable(up_rdata) && $stable(dn_rdata)))
        else $error("store read data changed under a held beat");
`endif

endmodule

/* design/mtrb_ring_mem.sv */
// byte store for the ring buffers of one direction
// one write port, one read port with registered read data
`timescale 1ns / 1ps

module mtrb_ring_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
